// ----- rtl/core/b2da_pkg.sv -----
`timescale 1ns / 1ps

package b2da_pkg;

   // ascii code of the digit zero
   localparam logic [5:0] ASCII_ZERO = 6'd48;

   // width of one bcd digit
   localparam int DIGIT_BITS = 4;

   // width of the binary value on the request channel
   localparam int REQ_VALUE_BITS = 64;

   // width of one ascii character on the response channel
   localparam int CHAR_BITS = 6;

   typedef logic [DIGIT_BITS-1:0] digit_type;

   // bit-serial converter control
   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_SHIFT,
      CONV_DONE
   } conv_state_type;

   // digit emitter control
   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SKIP,
      EMIT_SEND
   } emit_state_type;

endpackage

// ----- rtl/core/b2da_if.sv -----
`timescale 1ns / 1ps

// request channel: one binary value
interface b2da_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [b2da_pkg::REQ_VALUE_BITS-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// response channel: one ascii digit
interface b2da_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [b2da_pkg::CHAR_BITS-1:0]        ascii_char;
   logic                                  is_last;

   modport source (output valid, output ascii_char, output is_last, input ready);
   modport sink (input valid, input ascii_char, input is_last, output ready);
endinterface

// ----- rtl/core/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Converts an unsigned binary value (its low VALUE_BITS bits) into decimal ascii
// digits, most significant first, leading zeros dropped, zero sent as a single
// '0'; is_last marks the final digit. A bit-serial double-dabble shifter takes
// one request at a time: it loads the value, shifts it in one bit per cycle and
// holds the digits until the emitter takes them, accepting no new request until
// then. A separate emitter loads the digits, skips the leading zero digits one
// by one, starts sending and sends one digit per free output slot, and works in
// parallel with the shifter on the next request.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   b2da_req_if.sink    req_chan,
   b2da_rsp_if.source  rsp_chan
);

   // decimal digits needed for VALUE_BITS bits, floor(bits * log10(2)) + 1
   localparam int NUM_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;

   logic                                        bcd_valid;
   logic                                        bcd_ready;
   logic [NUM_DIGITS*b2da_pkg::DIGIT_BITS-1:0]  bcd_digits;

   // bit-serial binary to bcd shifter
   b2da_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .bcd_valid  (bcd_valid),
      .bcd_ready  (bcd_ready),
      .bcd_digits (bcd_digits)
   );

   // digit-serial ascii emitter
   b2da_emit #(
      .NUM_DIGITS (NUM_DIGITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .bcd_valid  (bcd_valid),
      .bcd_ready  (bcd_ready),
      .bcd_digits (bcd_digits),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- rtl/core/b2da_dabble.sv -----
`timescale 1ns / 1ps

module b2da_dabble #(
   parameter int VALUE_BITS = 64,
   parameter int NUM_DIGITS = 20
) (
   input  logic                                         clock,
   input  logic                                         reset,
   b2da_req_if.sink                                     req_chan,
   output logic                                         bcd_valid,
   input  logic                                         bcd_ready,
   output logic [NUM_DIGITS*b2da_pkg::DIGIT_BITS-1:0]   bcd_digits
);

   localparam int BCD_BITS = NUM_DIGITS * b2da_pkg::DIGIT_BITS;
   localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   b2da_pkg::conv_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0]    bin_ff, bin_in;
   logic [BCD_BITS-1:0]      bcd_ff, bcd_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [BCD_BITS-1:0]      bcd_adj;

   // add-3 correction on every digit lane before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] >= 4'd5) begin
            bcd_adj[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
               bcd_ff[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] + 4'd3;
         end else begin
            bcd_adj[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS] =
               bcd_ff[i*b2da_pkg::DIGIT_BITS +: b2da_pkg::DIGIT_BITS];
         end
      end
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         b2da_pkg::CONV_IDLE: begin
            if (req_chan.valid) begin
               bin_in   = req_chan.value[VALUE_BITS-1:0];
               bcd_in   = '0;
               cnt_in   = CNT_BITS'(VALUE_BITS - 1);
               state_in = b2da_pkg::CONV_SHIFT;
            end
         end
         b2da_pkg::CONV_SHIFT: begin
            bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = b2da_pkg::CONV_DONE;
            end
         end
         b2da_pkg::CONV_DONE: begin
            if (bcd_ready) begin
               state_in = b2da_pkg::CONV_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::CONV_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= b2da_pkg::CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // shift registers
   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign req_chan.ready = (state_ff == b2da_pkg::CONV_IDLE);
   assign bcd_valid      = (state_ff == b2da_pkg::CONV_DONE);
   assign bcd_digits     = bcd_ff;

endmodule

// ----- rtl/core/b2da_emit.sv -----
`timescale 1ns / 1ps

module b2da_emit #(
   parameter int NUM_DIGITS = 20
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         bcd_valid,
   output logic                                         bcd_ready,
   input  logic [NUM_DIGITS*b2da_pkg::DIGIT_BITS-1:0]   bcd_digits,
   b2da_rsp_if.source                                   rsp_chan
);

   localparam int BCD_BITS  = NUM_DIGITS * b2da_pkg::DIGIT_BITS;
   localparam int LEFT_BITS = $clog2(NUM_DIGITS + 1);

   b2da_pkg::emit_state_type       state_ff, state_in;
   logic [BCD_BITS-1:0]            dig_ff, dig_in;
   logic [LEFT_BITS-1:0]           left_ff, left_in;
   logic                           ovalid_ff, ovalid_in;
   logic [b2da_pkg::CHAR_BITS-1:0] char_ff, char_in;
   logic                           last_ff, last_in;
   b2da_pkg::digit_type            top_digit;
   logic                           slot_free;
   logic                           send;
   logic                           load;

   assign top_digit = dig_ff[BCD_BITS-1 -: b2da_pkg::DIGIT_BITS];
   assign slot_free = !ovalid_ff || rsp_chan.ready;
   assign load      = (state_ff == b2da_pkg::EMIT_IDLE) && bcd_valid;
   assign send      = (state_ff == b2da_pkg::EMIT_SEND) && slot_free;

   // leading zero skip, then one digit per free output slot
   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      left_in  = left_ff;
      case (state_ff)
         b2da_pkg::EMIT_IDLE: begin
            if (bcd_valid) begin
               dig_in   = bcd_digits;
               left_in  = LEFT_BITS'(NUM_DIGITS);
               state_in = b2da_pkg::EMIT_SKIP;
            end
         end
         b2da_pkg::EMIT_SKIP: begin
            if (top_digit == '0 && left_ff > LEFT_BITS'(1)) begin
               dig_in  = dig_ff << b2da_pkg::DIGIT_BITS;
               left_in = left_ff - 1'b1;
            end else begin
               state_in = b2da_pkg::EMIT_SEND;
            end
         end
         b2da_pkg::EMIT_SEND: begin
            if (slot_free) begin
               dig_in  = dig_ff << b2da_pkg::DIGIT_BITS;
               left_in = left_ff - 1'b1;
               if (left_ff == LEFT_BITS'(1)) begin
                  state_in = b2da_pkg::EMIT_IDLE;
               end
            end
         end
         default: begin
            state_in = b2da_pkg::EMIT_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      ovalid_in = ovalid_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (send) begin
         ovalid_in = 1'b1;
         char_in   = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
         last_in   = (left_ff == LEFT_BITS'(1));
      end else if (rsp_chan.ready) begin
         ovalid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= b2da_pkg::EMIT_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      left_ff <= left_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign bcd_ready           = (state_ff == b2da_pkg::EMIT_IDLE);
   assign rsp_chan.valid      = ovalid_ff;
   assign rsp_chan.ascii_char = char_ff;
   assign rsp_chan.is_last    = last_ff;

   // a loaded value always starts with the zero skip
   assert property (@(posedge clock) disable iff (reset)
      load |=> state_ff == b2da_pkg::EMIT_SKIP)
      else $error("emitter did not enter skip after load");

   // the final digit returns the emitter to idle
   assert property (@(posedge clock) disable iff (reset)
      send && left_ff == LEFT_BITS'(1) |=> state_ff == b2da_pkg::EMIT_IDLE)
      else $error("emitter did not finish after the final digit");

   // a busy emitter always has digits left
   assert property (@(posedge clock) disable iff (reset)
      state_ff != b2da_pkg::EMIT_IDLE |-> left_ff != '0)
      else $error("emitter busy with no digits left");

   // only valid bcd digits are sent
   assert property (@(posedge clock) disable iff (reset)
      send |-> top_digit <= 4'd9)
      else $error("digit out of decimal range");

endmodule
